>>> sv/format_directive_parser_unit_macros.svh
// Assertion macros shared by the format directive parser RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef FORMAT_DIRECTIVE_PARSER_UNIT_MACROS_SVH
`define FORMAT_DIRECTIVE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fdp_pkg.sv
// Package for the format directive parser: byte codes, result codes, phases, types.
// Depends on nothing.
`default_nettype none

package fdp_pkg;

  localparam int NUMBER_WIDTH_DEF = 16;
  localparam int QDEPTH           = 2;   // queue depth, power of two
  localparam int MAX_HOPS         = 6;   // longest chain of phases one byte can pass

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_I = 8'h49;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_L      = 8'h6C;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUPFLAG = 3'd1;
  localparam logic [2:0] ST_STARPOS = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_BADCONV = 3'd4;
  localparam logic [2:0] ST_NOPCT   = 3'd5;

  // Length modifier codes
  localparam logic [3:0] LK_NONE = 4'd0;
  localparam logic [3:0] LK_H    = 4'd1;
  localparam logic [3:0] LK_L    = 4'd2;
  localparam logic [3:0] LK_HH   = 4'd3;
  localparam logic [3:0] LK_LL   = 4'd4;
  localparam logic [3:0] LK_BIGL = 4'd5;
  localparam logic [3:0] LK_J    = 4'd6;
  localparam logic [3:0] LK_Z    = 4'd7;
  localparam logic [3:0] LK_T    = 4'd8;

  // Flag bit positions
  localparam logic [2:0] FB_HASH  = 3'd0;
  localparam logic [2:0] FB_ZERO  = 3'd1;
  localparam logic [2:0] FB_MINUS = 3'd2;
  localparam logic [2:0] FB_PLUS  = 3'd3;
  localparam logic [2:0] FB_SPACE = 3'd4;
  localparam logic [2:0] FB_QUOTE = 3'd5;
  localparam logic [2:0] FB_I     = 3'd6;

  // Mode bit positions
  localparam int MB_POS  = 0;
  localparam int MB_WARG = 1;
  localparam int MB_PARG = 2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_AFTER_PCT, PH_FIRST_NUM, PH_FLAGS,
    PH_WIDTH, PH_WSTAR_START, PH_WSTAR_NUM, PH_WIDTH_NUM,
    PH_DOT, PH_PREC, PH_PSTAR_START, PH_PSTAR_NUM,
    PH_PREC_NUM, PH_LEN, PH_LEN2, PH_CONV
  } phase_t;

  // One classified format byte
  typedef struct packed {
    logic [7:0] code;
    logic       is_zero;
    logic       is_pct;
    logic       is_dollar;
    logic       is_star;
    logic       is_dot;
    logic       is_lead;
    logic       is_digit;
    logic       is_flag;
    logic [2:0] flag_idx;
    logic       is_conv;
    logic       len_valid;
    logic       len_pair;   // h or l: may pair with a second letter
    logic [3:0] len_kind;
  } cls_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    cls_t item;
  } qhead_t;

endpackage

`default_nettype wire

>>> sv/fdp_front.sv
// Front end of the format directive parser: classifies each incoming byte.
// Depends on fdp_pkg.
`default_nettype none

module fdp_front (
  input  wire logic [7:0] char_code,
  output fdp_pkg::cls_t   cls
);
  import fdp_pkg::*;

  always_comb begin
    cls           = '0;
    cls.code      = char_code;
    cls.is_zero   = (char_code == CH_NUL);
    cls.is_pct    = (char_code == CH_PCT);
    cls.is_dollar = (char_code == CH_DOLLAR);
    cls.is_star   = (char_code == CH_STAR);
    cls.is_dot    = (char_code == CH_DOT);
    cls.is_lead   = char_code inside {[CH_ONE:CH_NINE]};
    cls.is_digit  = char_code inside {[CH_ZERO:CH_NINE]};
    cls.is_conv   = char_code inside {"d", "i", "o", "u", "x", "X", "e", "E", "f", "F",
                                      "g", "G", "a", "A", "c", "s", "C", "S", "p", "n",
                                      "m"};

    case (char_code)
      CH_HASH:    begin cls.is_flag = 1'b1; cls.flag_idx = FB_HASH;  end
      CH_ZERO:    begin cls.is_flag = 1'b1; cls.flag_idx = FB_ZERO;  end
      CH_MINUS:   begin cls.is_flag = 1'b1; cls.flag_idx = FB_MINUS; end
      CH_PLUS:    begin cls.is_flag = 1'b1; cls.flag_idx = FB_PLUS;  end
      CH_SPACE:   begin cls.is_flag = 1'b1; cls.flag_idx = FB_SPACE; end
      CH_QUOTE:   begin cls.is_flag = 1'b1; cls.flag_idx = FB_QUOTE; end
      CH_UPPER_I: begin cls.is_flag = 1'b1; cls.flag_idx = FB_I;     end
      default: ;
    endcase

    case (char_code)
      "h":      begin cls.len_valid = 1'b1; cls.len_pair = 1'b1; cls.len_kind = LK_H;    end
      "l":      begin cls.len_valid = 1'b1; cls.len_pair = 1'b1; cls.len_kind = LK_L;    end
      "q":      begin cls.len_valid = 1'b1; cls.len_kind = LK_LL;   end
      "L":      begin cls.len_valid = 1'b1; cls.len_kind = LK_BIGL; end
      "j":      begin cls.len_valid = 1'b1; cls.len_kind = LK_J;    end
      "z", "Z": begin cls.len_valid = 1'b1; cls.len_kind = LK_Z;    end
      "t":      begin cls.len_valid = 1'b1; cls.len_kind = LK_T;    end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/fdp_queue.sv
// Short register queue of classified bytes between front and back ends.
// Depends on fdp_pkg and format_directive_parser_unit_macros.svh.
`default_nettype none
`include "format_directive_parser_unit_macros.svh"

module fdp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  fdp_pkg::cls_t      push_item,
  output logic               full,
  input  wire logic          pop,
  output fdp_pkg::qhead_t    head
);
  import fdp_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cls_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `FDP_ASSERT_NOW(a_no_push_full, push, count_r != CW'(QDEPTH), "push into full queue")
  `FDP_ASSERT_NOW(a_no_pop_empty, pop, count_r != '0, "pop from empty queue")
  `FDP_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

>>> sv/fdp_back.sv
// Back end of the format directive parser: directive state machine and result register.
// Depends on fdp_pkg and format_directive_parser_unit_macros.svh.
`default_nettype none
`include "format_directive_parser_unit_macros.svh"

module fdp_back #(
  parameter int NUMBER_WIDTH = fdp_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  fdp_pkg::qhead_t  head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_conversion_char,
  output logic [3:0]       out_length_kind,
  output logic [15:0]      out_width_value,
  output logic [15:0]      out_precision_value,
  output logic [15:0]      out_arg_position,
  output logic [6:0]       out_flag_bits,
  output logic             out_positional,
  output logic             out_width_from_arg,
  output logic             out_precision_from_arg
);
  import fdp_pkg::*;

  localparam int NW = NUMBER_WIDTH;
  localparam int SW = (NW > 16) ? NW : 16;

  // Multiply by ten and add a digit, saturating at NW bits.
  function automatic logic [NW-1:0] acc_digit(input logic [NW-1:0] a, input logic [3:0] d);
    logic [NW+3:0] v;
    v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {NW'(0), d};
    return (v[NW+3:NW] != '0) ? {NW{1'b1}} : v[NW-1:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [NW-1:0] v);
    logic [SW-1:0] x;
    x = SW'(v);
    return (x > SW'(17'h0FFFF)) ? 16'hFFFF : x[15:0];
  endfunction

  phase_t        phase_r, phase_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [6:0]    flags_r, flags_nxt;
  logic [NW-1:0] width_r, width_nxt;
  logic [NW-1:0] prec_r, prec_nxt;
  logic [NW-1:0] pos_r, pos_nxt;
  logic [3:0]    len_r, len_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic          out_valid_r;

  // Step working variables
  phase_t        ph;
  logic [NW-1:0] acc, wst, pst, pos;
  logic [6:0]    flg;
  logic [3:0]    len;
  logic [2:0]    mode;
  logic          done, emit;
  logic [2:0]    st;
  logic [7:0]    conv;
  logic [NW-1:0] acc_step, lead_val;
  cls_t          c;

  assign c        = head.item;
  assign pop      = head.valid && (!out_valid_r || out_ready);
  assign acc_step = acc_digit(acc_r, c.code[3:0]);
  assign lead_val = NW'(c.code[3:0]);
  assign out_valid = out_valid_r;

  always_comb begin
    ph   = phase_r;
    acc  = acc_r;
    flg  = flags_r;
    wst  = width_r;
    pst  = prec_r;
    pos  = pos_r;
    len  = len_r;
    mode = mode_r;
    done = 1'b0;
    emit = 1'b0;
    st   = ST_OK;
    conv = CH_NUL;
    for (int i = 0; i < MAX_HOPS; i++) begin
      if (!done) begin
        case (ph)
          PH_IDLE: begin
            done = 1'b1;
            if (c.is_pct) begin
              ph = PH_AFTER_PCT;
            end else begin
              emit = 1'b1;
              st   = ST_NOPCT;
            end
          end
          PH_AFTER_PCT: begin
            if (c.is_pct) begin
              done = 1'b1; emit = 1'b1; conv = CH_PCT;
            end else if (c.is_lead) begin
              done = 1'b1; acc = lead_val; ph = PH_FIRST_NUM;
            end else begin
              ph = PH_FLAGS;
            end
          end
          PH_FIRST_NUM: begin
            if (c.is_digit) begin
              done = 1'b1; acc = acc_step;
            end else if (c.is_dollar) begin
              done = 1'b1; pos = acc; mode[MB_POS] = 1'b1; ph = PH_FLAGS;
            end else begin
              wst = acc; ph = PH_DOT;
            end
          end
          PH_FLAGS: begin
            if (c.is_flag) begin
              done = 1'b1;
              if (flg[c.flag_idx]) begin
                emit = 1'b1; st = ST_DUPFLAG;
              end else begin
                flg[c.flag_idx] = 1'b1;
              end
            end else begin
              ph = PH_WIDTH;
            end
          end
          PH_WIDTH: begin
            if (c.is_star) begin
              done = 1'b1;
              mode[MB_WARG] = 1'b1;
              ph = mode[MB_POS] ? PH_WSTAR_START : PH_DOT;
            end else if (c.is_lead) begin
              done = 1'b1; acc = lead_val; ph = PH_WIDTH_NUM;
            end else begin
              ph = PH_DOT;
            end
          end
          PH_WSTAR_START, PH_PSTAR_START: begin
            done = 1'b1;
            if (c.is_lead) begin
              acc = lead_val;
              ph  = (ph == PH_WSTAR_START) ? PH_WSTAR_NUM : PH_PSTAR_NUM;
            end else begin
              emit = 1'b1; st = ST_STARPOS;
            end
          end
          PH_WSTAR_NUM, PH_PSTAR_NUM: begin
            done = 1'b1;
            if (c.is_digit) begin
              acc = acc_step;
            end else if (c.is_dollar) begin
              if (ph == PH_WSTAR_NUM) begin
                wst = acc; ph = PH_DOT;
              end else begin
                pst = acc; ph = PH_LEN;
              end
            end else begin
              emit = 1'b1; st = ST_STARPOS;
            end
          end
          PH_WIDTH_NUM: begin
            if (c.is_digit) begin
              done = 1'b1; acc = acc_step;
            end else begin
              wst = acc; ph = PH_DOT;
            end
          end
          PH_DOT: begin
            if (c.is_dot) begin
              done = 1'b1; ph = PH_PREC;
            end else begin
              ph = PH_LEN;
            end
          end
          PH_PREC: begin
            if (c.is_star) begin
              done = 1'b1;
              mode[MB_PARG] = 1'b1;
              ph = mode[MB_POS] ? PH_PSTAR_START : PH_LEN;
            end else if (c.is_lead) begin
              done = 1'b1; acc = lead_val; ph = PH_PREC_NUM;
            end else begin
              ph = PH_LEN;
            end
          end
          PH_PREC_NUM: begin
            if (c.is_digit) begin
              done = 1'b1; acc = acc_step;
            end else begin
              pst = acc; ph = PH_LEN;
            end
          end
          PH_LEN: begin
            if (c.len_valid) begin
              done = 1'b1;
              len  = c.len_kind;
              ph   = c.len_pair ? PH_LEN2 : PH_CONV;
            end else begin
              ph = PH_CONV;
            end
          end
          PH_LEN2: begin
            if (len == LK_H && c.code == CH_H) begin
              done = 1'b1; len = LK_HH; ph = PH_CONV;
            end else if (len == LK_L && c.code == CH_L) begin
              done = 1'b1; len = LK_LL; ph = PH_CONV;
            end else begin
              ph = PH_CONV;
            end
          end
          PH_CONV: begin
            done = 1'b1;
            emit = 1'b1;
            if (c.is_conv) begin
              conv = c.code;
            end else if (c.is_zero) begin
              st = ST_TRUNC;
            end else begin
              st = ST_BADCONV;
            end
          end
          default: begin
            done = 1'b1; emit = 1'b1; st = ST_BADCONV;
          end
        endcase
      end
    end
    if (!done) begin
      emit = 1'b1;
      st   = ST_BADCONV;
    end

    // Drop the whole directive state once a result goes out
    if (emit) begin
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      flags_nxt = '0;
      width_nxt = '0;
      prec_nxt  = '0;
      pos_nxt   = '0;
      len_nxt   = LK_NONE;
      mode_nxt  = '0;
    end else begin
      phase_nxt = ph;
      acc_nxt   = acc;
      flags_nxt = flg;
      width_nxt = wst;
      prec_nxt  = pst;
      pos_nxt   = pos;
      len_nxt   = len;
      mode_nxt  = mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      flags_r     <= '0;
      width_r     <= '0;
      prec_r      <= '0;
      pos_r       <= '0;
      len_r       <= LK_NONE;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        flags_r <= flags_nxt;
        width_r <= width_nxt;
        prec_r  <= prec_nxt;
        pos_r   <= pos_nxt;
        len_r   <= len_nxt;
        mode_r  <= mode_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_status          <= st;
      out_conversion_char <= (st == ST_OK) ? conv : CH_NUL;
      if (st == ST_OK && conv != CH_PCT) begin
        out_length_kind        <= len;
        out_width_value        <= sat16(wst);
        out_precision_value    <= sat16(pst);
        out_arg_position       <= sat16(pos);
        out_flag_bits          <= flg;
        out_positional         <= mode[MB_POS];
        out_width_from_arg     <= mode[MB_WARG];
        out_precision_from_arg <= mode[MB_PARG];
      end else begin
        out_length_kind        <= LK_NONE;
        out_width_value        <= '0;
        out_precision_value    <= '0;
        out_arg_position       <= '0;
        out_flag_bits          <= '0;
        out_positional         <= 1'b0;
        out_width_from_arg     <= 1'b0;
        out_precision_from_arg <= 1'b0;
      end
    end
  end

  `FDP_ASSERT_NOW(a_idle_clean, phase_r == PH_IDLE,
    acc_r == '0 && flags_r == '0 && mode_r == '0 && len_r == LK_NONE,
    "stale directive state while idle")
  `FDP_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !pop,
    "byte consumed while result stalled")
  `FDP_ASSERT_NOW(a_error_zeroed, out_valid_r && out_status != ST_OK,
    out_conversion_char == CH_NUL && out_flag_bits == '0 && out_width_value == '0,
    "error result carries nonzero fields")

endmodule

`default_nettype wire

>>> sv/format_directive_parser_unit.sv
// Format directive parser: takes one format byte per request, starting at '%', and
// returns one result per directive (or per error). Byte and result are registered.
// Throughput: one byte per cycle unless the result stalls, set by the back-end step
// (phase chain plus one multiply-by-ten accumulate). Reset (rst_n low, sync) empties
// the queue, returns the parser to idle and drops any pending result.
// Depends on fdp_pkg, fdp_front, fdp_queue, fdp_back.
`default_nettype none

module format_directive_parser_unit #(
  parameter int NUMBER_WIDTH = fdp_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Byte request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_conversion_char,
  output logic [3:0]       out_length_kind,
  output logic [15:0]      out_width_value,
  output logic [15:0]      out_precision_value,
  output logic [15:0]      out_arg_position,
  output logic [6:0]       out_flag_bits,
  output logic             out_positional,
  output logic             out_width_from_arg,
  output logic             out_precision_from_arg
);
  import fdp_pkg::*;

  cls_t   in_cls;
  qhead_t q_head;
  logic   q_full;
  logic   q_pop;
  logic   q_push;

  // Take a request whenever the queue has room; the back end drains it on its own.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Classify the byte on its way into the queue
  fdp_front u_front (
    .char_code (in_char_code),
    .cls       (in_cls)
  );

  // Hold classified bytes so front and back stall independently
  fdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (in_cls),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // Advance the directive state machine and register results
  fdp_back #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (q_head),
    .pop                    (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_conversion_char    (out_conversion_char),
    .out_length_kind        (out_length_kind),
    .out_width_value        (out_width_value),
    .out_precision_value    (out_precision_value),
    .out_arg_position       (out_arg_position),
    .out_flag_bits          (out_flag_bits),
    .out_positional         (out_positional),
    .out_width_from_arg     (out_width_from_arg),
    .out_precision_from_arg (out_precision_from_arg)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for format_directive_parser_unit: feeds format bytes, predicts each
// directive result with an in-bench parser and compares every field. Depends on fdp_pkg.
module tb;
  import fdp_pkg::*;

  // Long receiver hold-off, watchdog limit and settle time at the end.
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1050;

  // Flag characters in flag-bit order, and the accepted conversion letters.
  localparam logic [8*7-1:0]  FLAG_CHARS   = "#0-+ 'I";
  localparam logic [8*21-1:0] CONV_LETTERS = "diouxXeEfFgGaAcsCSpnm";

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  conv;
    logic [3:0]  lenk;
    logic [15:0] wid;
    logic [15:0] prec;
    logic [15:0] apos;
    logic [6:0]  flags;
    logic        pos;
    logic        warg;
    logic        parg;
  } exp_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_conversion_char;
  logic [3:0]  out_length_kind;
  logic [15:0] out_width_value;
  logic [15:0] out_precision_value;
  logic [15:0] out_arg_position;
  logic [6:0]  out_flag_bits;
  logic        out_positional;
  logic        out_width_from_arg;
  logic        out_precision_from_arg;

  format_directive_parser_unit u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_char_code           (in_char_code),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_conversion_char    (out_conversion_char),
    .out_length_kind        (out_length_kind),
    .out_width_value        (out_width_value),
    .out_precision_value    (out_precision_value),
    .out_arg_position       (out_arg_position),
    .out_flag_bits          (out_flag_bits),
    .out_positional         (out_positional),
    .out_width_from_arg     (out_width_from_arg),
    .out_precision_from_arg (out_precision_from_arg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: phase and stores of the directive being assembled.
  // ---------------------------------------------------------------------------
  phase_t      ph = PH_IDLE;
  logic [15:0] acc, wid, prec, apos;
  logic [6:0]  flg;
  logic [3:0]  lenk;
  logic        pos_m, warg_m, parg_m;

  exp_result_t expected_directives[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;

  // Shared controls: burst drops all idling, hold_req asks the receiver for a long hold-off.
  bit          burst = 1'b0;
  bit          hold_req = 1'b0;

  // Directed rows: text, trailing zero byte, and a typed result where one is pinned.
  string       row_text[$];
  bit          row_nul[$];
  bit          row_pin[$];
  exp_result_t row_res[$];
  bit          pin_valid = 1'b0;
  exp_result_t pin_res;

  logic [7:0]  dir_q[$];

  function automatic void clear_parser();
    ph = PH_IDLE;
    acc = '0; wid = '0; prec = '0; apos = '0;
    flg = '0; lenk = LK_NONE;
    pos_m = 1'b0; warg_m = 1'b0; parg_m = 1'b0;
  endfunction

  // Close the directive: build its result from the stores and return to idle.
  function automatic exp_result_t close_directive(logic [2:0] st, logic [7:0] cv);
    exp_result_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.conv = cv;
      if (cv != CH_PCT) begin
        r.lenk  = lenk;
        r.wid   = wid;
        r.prec  = prec;
        r.apos  = apos;
        r.flags = flg;
        r.pos   = pos_m;
        r.warg  = warg_m;
        r.parg  = parg_m;
      end
    end
    clear_parser();
    return r;
  endfunction

  // Multiply-by-ten accumulate, saturating at 16 bits.
  function automatic void add_digit(logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - CH_ZERO);
    acc = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic int flag_index(logic [7:0] c);
    int k;
    for (k = 0; k < 7; k++)
      if (FLAG_CHARS[8*(6-k) +: 8] == c) return k;
    return -1;
  endfunction

  function automatic bit is_conv_letter(logic [7:0] c);
    int k;
    for (k = 0; k < 21; k++)
      if (CONV_LETTERS[8*(20-k) +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the parser mirror by one byte. A byte that only ends a number or a lone
  // h/l falls through to the next phase within the same step.
  task automatic parse_format_byte(input logic [7:0] c, output bit fired,
                                   output exp_result_t r);
    bit done;
    bit lead;
    bit digit;
    int fb;
    fired = 1'b0;
    r = '0;
    done = 1'b0;
    lead = (c >= CH_ONE) && (c <= CH_NINE);
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    while (!done) begin
      case (ph)
        PH_IDLE: begin
          if (c == CH_PCT) begin
            clear_parser();
            ph = PH_AFTER_PCT;
          end else begin
            r = close_directive(ST_NOPCT, CH_NUL);
            fired = 1'b1;
          end
          done = 1'b1;
        end
        PH_AFTER_PCT: begin
          if (c == CH_PCT) begin
            r = close_directive(ST_OK, CH_PCT);
            fired = 1'b1;
            done = 1'b1;
          end else if (lead) begin
            acc = 16'(c - CH_ZERO);
            ph = PH_FIRST_NUM;
            done = 1'b1;
          end else begin
            ph = PH_FLAGS;
          end
        end
        PH_FIRST_NUM: begin
          if (digit) begin
            add_digit(c);
            done = 1'b1;
          end else if (c == CH_DOLLAR) begin
            apos = acc;
            pos_m = 1'b1;
            ph = PH_FLAGS;
            done = 1'b1;
          end else begin
            // a bare leading number is the width; flags are then closed
            wid = acc;
            ph = PH_DOT;
          end
        end
        PH_FLAGS: begin
          fb = flag_index(c);
          if (fb >= 0) begin
            if (flg[fb]) begin
              r = close_directive(ST_DUPFLAG, CH_NUL);
              fired = 1'b1;
            end else begin
              flg[fb] = 1'b1;
            end
            done = 1'b1;
          end else begin
            ph = PH_WIDTH;
          end
        end
        PH_WIDTH: begin
          if (c == CH_STAR) begin
            warg_m = 1'b1;
            ph = pos_m ? PH_WSTAR_START : PH_DOT;
            done = 1'b1;
          end else if (lead) begin
            acc = 16'(c - CH_ZERO);
            ph = PH_WIDTH_NUM;
            done = 1'b1;
          end else begin
            ph = PH_DOT;
          end
        end
        PH_WSTAR_START, PH_PSTAR_START: begin
          if (lead) begin
            acc = 16'(c - CH_ZERO);
            ph = (ph == PH_WSTAR_START) ? PH_WSTAR_NUM : PH_PSTAR_NUM;
          end else begin
            r = close_directive(ST_STARPOS, CH_NUL);
            fired = 1'b1;
          end
          done = 1'b1;
        end
        PH_WSTAR_NUM, PH_PSTAR_NUM: begin
          if (digit) begin
            add_digit(c);
          end else if (c == CH_DOLLAR) begin
            if (ph == PH_WSTAR_NUM) begin
              wid = acc;
              ph = PH_DOT;
            end else begin
              prec = acc;
              ph = PH_LEN;
            end
          end else begin
            r = close_directive(ST_STARPOS, CH_NUL);
            fired = 1'b1;
          end
          done = 1'b1;
        end
        PH_WIDTH_NUM: begin
          if (digit) begin
            add_digit(c);
            done = 1'b1;
          end else begin
            wid = acc;
            ph = PH_DOT;
          end
        end
        PH_DOT: begin
          if (c == CH_DOT) begin
            ph = PH_PREC;
            done = 1'b1;
          end else begin
            ph = PH_LEN;
          end
        end
        PH_PREC: begin
          if (c == CH_STAR) begin
            parg_m = 1'b1;
            ph = pos_m ? PH_PSTAR_START : PH_LEN;
            done = 1'b1;
          end else if (lead) begin
            acc = 16'(c - CH_ZERO);
            ph = PH_PREC_NUM;
            done = 1'b1;
          end else begin
            ph = PH_LEN;
          end
        end
        PH_PREC_NUM: begin
          if (digit) begin
            add_digit(c);
            done = 1'b1;
          end else begin
            prec = acc;
            ph = PH_LEN;
          end
        end
        PH_LEN: begin
          done = 1'b1;
          case (c)
            CH_H:     begin lenk = LK_H;    ph = PH_LEN2; end
            CH_L:     begin lenk = LK_L;    ph = PH_LEN2; end
            "q":      begin lenk = LK_LL;   ph = PH_CONV; end
            "L":      begin lenk = LK_BIGL; ph = PH_CONV; end
            "j":      begin lenk = LK_J;    ph = PH_CONV; end
            "z", "Z": begin lenk = LK_Z;    ph = PH_CONV; end
            "t":      begin lenk = LK_T;    ph = PH_CONV; end
            default:  begin ph = PH_CONV;   done = 1'b0; end
          endcase
        end
        PH_LEN2: begin
          if (lenk == LK_H && c == CH_H) begin
            lenk = LK_HH;
            ph = PH_CONV;
            done = 1'b1;
          end else if (lenk == LK_L && c == CH_L) begin
            lenk = LK_LL;
            ph = PH_CONV;
            done = 1'b1;
          end else begin
            ph = PH_CONV;
          end
        end
        default: begin
          if (is_conv_letter(c)) r = close_directive(ST_OK, c);
          else if (c == CH_NUL) r = close_directive(ST_TRUNC, CH_NUL);
          else r = close_directive(ST_BADCONV, CH_NUL);
          fired = 1'b1;
          done = 1'b1;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Check each accepted result, then advance the mirror on each accepted request.
  always @(posedge clk) begin : scoreboard
    bit          fired;
    exp_result_t r;
    exp_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_directives.size() == 0) begin
          report_mismatch($sformatf("result with none pending, status %0d", out_status));
        end else begin
          want = expected_directives.pop_front();
          check_field("status", 16'(out_status), 16'(want.status));
          check_field("conversion_char", 16'(out_conversion_char), 16'(want.conv));
          check_field("length_kind", 16'(out_length_kind), 16'(want.lenk));
          check_field("width_value", out_width_value, want.wid);
          check_field("precision_value", out_precision_value, want.prec);
          check_field("arg_position", out_arg_position, want.apos);
          check_field("flag_bits", 16'(out_flag_bits), 16'(want.flags));
          check_field("positional", 16'(out_positional), 16'(want.pos));
          check_field("width_from_arg", 16'(out_width_from_arg), 16'(want.warg));
          check_field("precision_from_arg", 16'(out_precision_from_arg),
                      16'(want.parg));
        end
      end
      if (in_valid && in_ready) begin
        parse_format_byte(in_char_code, fired, r);
        if (fired) begin
          // a pinned directed row replaces the mirror's answer with its typed result
          if (pin_valid) begin
            r = pin_res;
            pin_valid = 1'b0;
          end
          expected_directives.push_back(r);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the block to fill and stall its input
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  // Offer one byte request: idle a random gap, raise valid, hold until accepted.
  // Entered and left at a falling edge; valid stays high on return.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_char_code = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic exp_result_t typed_result(logic [2:0] st, logic [7:0] cv,
                                               logic [15:0] w);
    exp_result_t r;
    r = '0;
    r.status = st;
    r.conv = cv;
    r.wid = w;
    return r;
  endfunction

  task automatic add_row(string s, bit nul, bit pinned, exp_result_t r);
    row_text.push_back(s);
    row_nul.push_back(nul);
    row_pin.push_back(pinned);
    row_res.push_back(r);
  endtask

  task automatic push_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) dir_q.push_back(s[k]);
  endtask

  task automatic push_number(int unsigned v);
    push_text($sformatf("%0d", v));
  endtask

  // Mostly small numbers; a few wide ones to drive saturation.
  function automatic int unsigned pick_number();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 99);
    if (r < 19) return $urandom_range(100, 65535);
    return $urandom_range(65536, 9999999);
  endfunction

  // Star argument; with a position in force it normally carries its own "N$".
  task automatic push_star(bit posn);
    dir_q.push_back(CH_STAR);
    if (posn && $urandom_range(0, 9) != 0) begin
      push_number(pick_number());
      dir_q.push_back(CH_DOLLAR);
    end
  endtask

  // Build one directive with random content: mostly well formed, some broken or cut short,
  // and a little plain noise.
  task automatic gen_directive();
    bit posn;
    int k;
    int n;
    int unsigned r;
    dir_q.delete();
    r = $urandom_range(0, 99);
    if (r < 4) begin
      dir_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    dir_q.push_back(CH_PCT);
    if (r < 9) begin
      dir_q.push_back(CH_PCT);
      return;
    end
    posn = ($urandom_range(0, 2) == 0);
    if (posn) begin
      push_number(pick_number());
      dir_q.push_back(CH_DOLLAR);
    end
    n = $urandom_range(0, 3);
    for (k = 0; k < n; k++) dir_q.push_back(FLAG_CHARS[8*$urandom_range(0, 6) +: 8]);
    case ($urandom_range(0, 3))
      0: ;
      1: push_star(posn);
      default: push_number(pick_number());
    endcase
    if ($urandom_range(0, 1)) begin
      dir_q.push_back(CH_DOT);
      case ($urandom_range(0, 3))
        0: ;
        1: push_star(posn);
        default: push_number(pick_number());
      endcase
    end
    case ($urandom_range(0, 10))
      1:  push_text("h");
      2:  push_text("hh");
      3:  push_text("l");
      4:  push_text("ll");
      5:  push_text("q");
      6:  push_text("L");
      7:  push_text("j");
      8:  push_text("z");
      9:  push_text("Z");
      10: push_text("t");
      default: ;
    endcase
    if ($urandom_range(0, 19) != 0) dir_q.push_back(CONV_LETTERS[8*$urandom_range(0, 20) +: 8]);
    else dir_q.push_back(8'($urandom_range(0, 255)));
    // cut the string short now and then
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, dir_q.size() - 1);
      while (dir_q.size() > n) void'(dir_q.pop_back());
      dir_q.push_back(CH_NUL);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int i;
    int k;
    int sent;
    bit pressed;
    bit paused;
    logic [7:0] b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = CH_NUL;
    pressed = 1'b0;
    paused = 1'b0;
    clear_parser();

    // Directed table: text, trailing zero byte, pinned, typed result.
    add_row("%%",       1'b0, 1'b1, typed_result(ST_OK, CH_PCT, 16'd0));
    add_row("A",        1'b0, 1'b1, typed_result(ST_NOPCT, CH_NUL, 16'd0));
    add_row("",         1'b1, 1'b1, typed_result(ST_NOPCT, CH_NUL, 16'd0));
    add_row("\377",     1'b0, 1'b1, typed_result(ST_NOPCT, CH_NUL, 16'd0));
    add_row("%##",      1'b0, 1'b1, typed_result(ST_DUPFLAG, CH_NUL, 16'd0));
    add_row("%",        1'b1, 1'b1, typed_result(ST_TRUNC, CH_NUL, 16'd0));
    add_row("%y",       1'b0, 1'b1, typed_result(ST_BADCONV, CH_NUL, 16'd0));
    add_row("%d",       1'b0, 1'b1, typed_result(ST_OK, "d", 16'd0));
    add_row("%65536d",  1'b0, 1'b1, typed_result(ST_OK, "d", 16'hFFFF));
    add_row("%1$*d",    1'b0, 1'b1, typed_result(ST_STARPOS, CH_NUL, 16'd0));
    add_row("%1$.*d",   1'b0, 1'b1, typed_result(ST_STARPOS, CH_NUL, 16'd0));
    add_row("%2$*5x",   1'b0, 1'b1, typed_result(ST_STARPOS, CH_NUL, 16'd0));
    add_row("%1$.*3",   1'b1, 1'b1, typed_result(ST_STARPOS, CH_NUL, 16'd0));
    // a leading number without '$' is the width, so a flag after it is no conversion
    add_row("%5-",      1'b0, 1'b1, typed_result(ST_BADCONV, CH_NUL, 16'd0));
    add_row("%3$#0-+ 'I*2$.*1$hhX", 1'b0, 1'b0, '0);
    add_row("%12.99999lc", 1'b0, 1'b0, '0);
    add_row("%*.*Lf",   1'b0, 1'b0, '0);
    add_row("%0.zn",    1'b0, 1'b0, '0);
    add_row("%7$1234567tp", 1'b0, 1'b0, '0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table.
    for (i = 0; i < row_text.size(); i++) begin
      pin_valid = row_pin[i];
      pin_res = row_res[i];
      for (k = 0; k < row_text[i].len(); k++) send_byte(row_text[i][k]);
      if (row_nul[i]) send_byte(CH_NUL);
    end

    // Random directives.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      // toggle stretches with no idling on either side
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (!pressed && sent >= 300) begin
        // hold the receiver off while offering a stream of stray bytes back to back
        pressed = 1'b1;
        hold_req = 1'b1;
        burst = 1'b1;
        for (k = 0; k < 40; k++) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_PCT) b = CH_NUL;
          send_byte(b);
        end
        burst = 1'b0;
        sent += 40;
      end
      if (!paused && sent >= 700) begin
        // pause the sender until every pending result has drained
        paused = 1'b1;
        in_valid = 1'b0;
        while (expected_directives.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      gen_directive();
      for (k = 0; k < dir_q.size(); k++) send_byte(dir_q[k]);
      sent += dir_q.size();
    end
    in_valid = 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    while (expected_directives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
